>>> rtl/icv3_pkg.sv
// Shared types and constants for the 3x3 symmetric convolution block.
package icv3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int FRAC_BITS  = 12;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration register indexes
  localparam logic [2:0] REG_COEF_CENTER  = 3'd0;
  localparam logic [2:0] REG_COEF_EDGE    = 3'd1;
  localparam logic [2:0] REG_COEF_CORNER  = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;
  localparam logic [2:0] REG_BORDER_VALUE = 3'd5;

  localparam logic signed [17:0] COEF_CENTER_RST = 18'sd16384;
  localparam logic signed [17:0] COEF_EDGE_RST   = -18'sd4096;
  localparam logic signed [17:0] COEF_CORNER_RST = 18'sd0;
  localparam logic [10:0]        WIDTH_RST       = 11'd640;
  localparam logic [12:0]        HEIGHT_RST      = 13'd480;
  localparam logic [7:0]         BORDER_RST      = 8'd255;

  typedef struct packed {
    logic signed [17:0] center;
    logic signed [17:0] edge_w;
    logic signed [17:0] corner;
  } coef_t;

  typedef struct packed {
    logic [10:0] width;
    logic [12:0] height;
    logic [7:0]  border;
  } frame_cfg_t;

  // One window reduced by symmetry: center pixel, sum of edges, sum of corners
  typedef struct packed {
    logic [7:0] center;
    logic [9:0] edges;
    logic [9:0] corners;
    logic       row_end;
    logic       frame_end;
  } res_t;

  // Queue entry: one or two results caused by one input word
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } qent_t;

endpackage

>>> rtl/icv3_front.sv
// Front end: input handshake, raster counters, line stores and 3x3 window.
module icv3_front (
  input  logic                    clk,
  input  logic                    rst,
  input  icv3_pkg::frame_cfg_t    fcfg,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // [7:0] pixel_in
  input  logic                    s_tuser,   // [0] func (1 = flush tick)
  input  logic [icv3_pkg::FIFO_AW:0] fifo_count,
  output logic                    push,
  output icv3_pkg::qent_t         push_data
);
  import icv3_pkg::*;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             draining;

  logic [10:0] w_eff;
  logic [10:0] w_last;
  logic [12:0] h_eff;
  logic        accept, take, is_last, row_done;
  logic [COL_W-1:0] col_c;

  // stage 1 registers
  logic             s1_v;
  logic [COL_W-1:0] s1_c;
  logic [7:0]       s1_px;
  logic             s1_first, s1_last, s1_drain, s1_ge1, s1_ge2;

  logic [7:0] upper [MAX_WIDTH];
  logic [7:0] lower [MAX_WIDTH];
  logic [7:0] up_rd, lo_rd;

  logic [2:0][2:0][7:0] win;     // [column][row]
  logic [2:0][2:0][7:0] base, win_n, win_m;
  logic [7:0] top, mid, bot;
  logic       a_v, b_v;
  res_t       res_a, res_b;

  function automatic res_t reduce(input logic [2:0][2:0][7:0] w, input logic re,
                                  input logic fe);
    res_t r;
    r.center    = w[1][1];
    r.edges     = {2'b0, w[1][0]} + {2'b0, w[1][2]} + {2'b0, w[0][1]} + {2'b0, w[2][1]};
    r.corners   = {2'b0, w[0][0]} + {2'b0, w[0][2]} + {2'b0, w[2][0]} + {2'b0, w[2][2]};
    r.row_end   = re;
    r.frame_end = fe;
    return r;
  endfunction

  always_comb begin
    if (fcfg.width < 11'd2) begin
      w_eff = 11'd2;
    end else if (fcfg.width > 11'(MAX_WIDTH)) begin
      w_eff = 11'(MAX_WIDTH);
    end else begin
      w_eff = fcfg.width;
    end
    if (fcfg.height < 13'd2) begin
      h_eff = 13'd2;
    end else if (fcfg.height > 13'(MAX_HEIGHT)) begin
      h_eff = 13'(MAX_HEIGHT);
    end else begin
      h_eff = fcfg.height;
    end
  end

  assign w_last   = w_eff - 11'd1;
  assign col_c    = ({1'b0, col} >= w_eff) ? w_last[COL_W-1:0] : col;
  assign is_last  = ({1'b0, col_c} == w_last);
  assign row_done = (({1'b0, row}) + 13'd1) >= h_eff;

  // keep one queue slot free for the word in stage 1 plus one for this word
  assign s_tready = ({1'b0, fifo_count} + {{(FIFO_AW + 1){1'b0}}, s1_v}) <
                    (FIFO_AW + 2)'(FIFO_DEPTH);
  assign accept = s_tvalid && s_tready;
  // a flush tick outside the drain row is dropped
  assign take   = accept && !(!draining && s_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      draining <= 1'b0;
      s1_v     <= 1'b0;
    end else begin
      s1_v <= take;
      if (take) begin
        if (is_last) begin
          col <= '0;
          if (draining) begin
            draining <= 1'b0;
            row      <= '0;
          end else if (row_done) begin
            draining <= 1'b1;
          end else begin
            row <= row + ROW_W'(1);
          end
        end else begin
          col <= col_c + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_c     <= col_c;
      s1_px    <= s_tdata;
      s1_first <= (col_c == '0);
      s1_last  <= is_last;
      s1_drain <= draining;
      s1_ge1   <= draining || (row != '0);
      s1_ge2   <= draining || (row >= ROW_W'(2));
    end
  end

  // line stores: lower written on take outside the drain row, upper takes the old lower word next cycle
  always_ff @(posedge clk) begin
    if (take) begin
      lo_rd <= lower[col_c];
      if (!draining) begin
        lower[col_c] <= s_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      up_rd <= upper[col_c];
    end
    if (s1_v && !s1_drain) begin
      upper[s1_c] <= lo_rd;
    end
  end

  always_comb begin
    top = s1_ge2 ? up_rd : fcfg.border;
    mid = s1_ge1 ? lo_rd : fcfg.border;
    bot = s1_drain ? fcfg.border : s1_px;
    base = s1_first ? {9{fcfg.border}} : win;
    win_n[0] = base[1];
    win_n[1] = base[2];
    win_n[2] = {bot, mid, top};
    win_m[0] = win_n[1];
    win_m[1] = win_n[2];
    win_m[2] = {3{fcfg.border}};
    a_v   = s1_v && s1_ge1 && !s1_first;
    b_v   = s1_v && s1_ge1 && s1_last;
    res_a = reduce(win_n, 1'b0, 1'b0);
    res_b = reduce(win_m, 1'b1, s1_drain);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= {9{BORDER_RST}};
    end else if (s1_v) begin
      win <= (s1_last && s1_ge1) ? win_m : win_n;
    end
  end

  assign push         = a_v || b_v;
  assign push_data.two = a_v && b_v;
  assign push_data.r0  = a_v ? res_a : res_b;
  assign push_data.r1  = res_b;

endmodule

>>> rtl/icv3_fifo.sv
// Short queue between front and back end, one entry per input word that causes a result.
module icv3_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  icv3_pkg::qent_t             push_data,
  input  logic                        pop,
  output logic                        head_valid,
  output icv3_pkg::qent_t             head,
  output logic [icv3_pkg::FIFO_AW:0]  count
);
  import icv3_pkg::*;

  qent_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

endmodule

>>> rtl/icv3_back.sv
// Back end: weighted sum of the reduced window, clamp and output register.
module icv3_back (
  input  logic              clk,
  input  logic              rst,
  input  icv3_pkg::coef_t   coefs,
  input  logic              head_valid,
  input  icv3_pkg::qent_t   head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] pixel_out
  output logic              m_tlast,   // row_end
  output logic              m_tuser    // [0] frame_end
);
  import icv3_pkg::*;

  logic half;
  res_t sel;
  logic take;

  logic               p_v, p_re, p_fe;
  logic signed [26:0] p_c;
  logic signed [28:0] p_e, p_k;

  logic               s_v, s_re, s_fe;
  logic signed [30:0] sum;

  logic o_ready, s_ready, p_ready;

  assign o_ready = !m_tvalid || m_tready;
  assign s_ready = !s_v || o_ready;
  assign p_ready = !p_v || s_ready;

  assign sel  = half ? head.r1 : head.r0;
  assign take = head_valid && p_ready;
  // a two-result entry leaves the queue after its second word
  assign pop  = take && (!head.two || half);

  always_ff @(posedge clk) begin
    if (rst) begin
      half     <= 1'b0;
      p_v      <= 1'b0;
      s_v      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        half <= head.two && !half;
      end
      if (p_ready) begin
        p_v <= take;
      end
      if (s_ready) begin
        s_v <= p_v;
      end
      if (o_ready) begin
        m_tvalid <= s_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && take) begin
      p_c  <= coefs.center * $signed({1'b0, sel.center});
      p_e  <= coefs.edge_w * $signed({1'b0, sel.edges});
      p_k  <= coefs.corner * $signed({1'b0, sel.corners});
      p_re <= sel.row_end;
      p_fe <= sel.frame_end;
    end
    if (s_ready && p_v) begin
      sum  <= $signed({{4{p_c[26]}}, p_c}) + $signed({{2{p_e[28]}}, p_e}) +
              $signed({{2{p_k[28]}}, p_k});
      s_re <= p_re;
      s_fe <= p_fe;
    end
    if (o_ready && s_v) begin
      if (sum[30] || sum == '0) begin
        m_tdata <= 8'd0;
      end else if (|sum[30:FRAC_BITS+8]) begin
        m_tdata <= 8'd255;
      end else begin
        m_tdata <= sum[FRAC_BITS+7:FRAC_BITS];
      end
      m_tlast <= s_re;
      m_tuser <= s_fe;
    end
  end

endmodule

>>> rtl/image_conv3x3_symmetric_unit.sv
// Top level: configuration registers and the front/queue/back pipeline.
//
// Streaming 3x3 convolution with a symmetric kernel over 8-bit grayscale.
// Input stream (s_*): one word per pixel in raster order; tuser=1 marks a
// flush tick. After the last row of a frame, image_width flush ticks (or
// pixels, whose value is ignored) drain the final output row.
// Output stream (m_*): filtered pixels; tlast marks the last pixel of an
// output row, tuser the last pixel of the frame. The result for pixel
// (r-1, c-1) is caused by input pixel (r, c); a row end input word after the
// first row causes two results.
// A result reaches m_tvalid through the line store read, the queue and the
// multiply, sum and clamp registers once its causing input word is taken.
// Throughput: one input word per cycle while s_tready is high; output one word
// per cycle, and the 4-entry queue soaks up the extra result of each row end.
// Configuration: cfg_we writes register cfg_addr; the user writes only while
// the block is idle; not enforced by the block. Reset (rst, synchronous)
// restores the Laplacian kernel, 640x480, border 255 and starts a new frame.
// A stalled m_tready fills the queue, then holds s_tready low; no word is lost.
module image_conv3x3_symmetric_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel_in
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] pixel_out
  output logic        m_tlast,   // row_end
  output logic        m_tuser,   // [0] frame_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [17:0] cfg_data
);
  import icv3_pkg::*;

  coef_t      coefs;
  frame_cfg_t fcfg;

  logic                 push, pop, head_valid;
  qent_t                push_data, head;
  logic [FIFO_AW:0]     fifo_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.center <= COEF_CENTER_RST;
      coefs.edge_w <= COEF_EDGE_RST;
      coefs.corner <= COEF_CORNER_RST;
      fcfg.width   <= WIDTH_RST;
      fcfg.height  <= HEIGHT_RST;
      fcfg.border  <= BORDER_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COEF_CENTER:  coefs.center <= cfg_data;
        REG_COEF_EDGE:    coefs.edge_w <= cfg_data;
        REG_COEF_CORNER:  coefs.corner <= cfg_data;
        REG_IMAGE_WIDTH:  fcfg.width   <= cfg_data[10:0];
        REG_IMAGE_HEIGHT: fcfg.height  <= cfg_data[12:0];
        REG_BORDER_VALUE: fcfg.border  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  icv3_front u_front (
    .clk        (clk),
    .rst        (rst),
    .fcfg       (fcfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .fifo_count (fifo_count),
    .push       (push),
    .push_data  (push_data)
  );

  icv3_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (fifo_count)
  );

  icv3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .coefs      (coefs),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
